// File: rtl/core/dpwp_pkg.sv
// shared types, constants and helpers for the depth pixel to world point core
package dpwp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PIX_CMP_W  = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRINCIPAL_POINT = 3'd0,
    REG_INVERSE_FOCAL   = 3'd1,
    REG_INV_DEPTH_SCALE = 3'd2,
    REG_ROTATION_ROW0   = 3'd3,
    REG_ROTATION_ROW1   = 3'd4,
    REG_ROTATION_ROW2   = 3'd5,
    REG_TRANSLATION     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0]             cx;
    logic [15:0]             cy;
    logic [23:0]             inv_fx;
    logic [23:0]             inv_fy;
    logic [23:0]             inv_depth_scale;
    logic [2:0][2:0][19:0]   rot;
    logic [2:0][20:0]        trans;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    logic [10:0] column;
    logic [10:0] row;
    logic [15:0] depth;
    color_t      color;
  } pix_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    color_t             color;
  } pt_t;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/depth_pixel_to_world_point_core.sv
// top level: rgb-d pixel stream in, saturated world point stream out
// throughput: one pixel per cycle unless the output stalls; seven register stages,
// each with a valid bit, the last one being the output register
// zero-depth and out-of-image pixels are dropped in the first stage
// reset clears all stage valid bits and sets every configuration register to zero
module depth_pixel_to_world_point_core #(
  parameter int unsigned COLUMN_LIMIT = 2048,
  parameter int unsigned ROW_LIMIT    = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // column, row, depth_raw, blue_in, green_in, red_in, 2 zero bits
  input  logic [63:0]                     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // point_x, point_y, point_z, blue_out, green_out, red_out
  output logic [119:0]                    m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dpwp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dpwp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dpwp_pkg::*;

  cfg_t cfg;
  pix_t pix;
  pt_t  cam_pt, out_pt;
  logic cam_valid, cam_ready;

  assign pix.column      = s_axis_tdata[10:0];
  assign pix.row         = s_axis_tdata[21:11];
  assign pix.depth       = s_axis_tdata[37:22];
  assign pix.color.blue  = s_axis_tdata[45:38];
  assign pix.color.green = s_axis_tdata[53:46];
  assign pix.color.red   = s_axis_tdata[61:54];

  dpwp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dpwp_camera #(
    .COLUMN_LIMIT (COLUMN_LIMIT),
    .ROW_LIMIT    (ROW_LIMIT)
  ) u_camera (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pix_i       (pix),
    .out_valid_o (cam_valid),
    .out_ready_i (cam_ready),
    .pt_o        (cam_pt)
  );

  dpwp_pose u_pose (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (cam_valid),
    .in_ready_o  (cam_ready),
    .pt_i        (cam_pt),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pt_o        (out_pt)
  );

  assign m_axis_tdata = {out_pt.color.red, out_pt.color.green, out_pt.color.blue,
                         out_pt.z, out_pt.y, out_pt.x};

  // a ready sink never stalls the input
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is ready");

  a_out_clear_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_INV_DEPTH_SCALE)
    |=> cfg.inv_depth_scale == $past(cfg_data_i[23:0]))
    else $error("depth scale register not updated by transfer");

endmodule

// File: rtl/core/dpwp_cfg_regs.sv
// configuration register file with write channel
module dpwp_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dpwp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dpwp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output dpwp_pkg::cfg_t                   cfg_o
);
  import dpwp_pkg::*;

  logic [31:0] pp_q;
  logic [47:0] ifoc_q;
  logic [23:0] ids_q;
  logic [59:0] row0_q, row1_q, row2_q;
  logic [62:0] trans_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q    <= '0;
      ifoc_q  <= '0;
      ids_q   <= '0;
      row0_q  <= '0;
      row1_q  <= '0;
      row2_q  <= '0;
      trans_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PRINCIPAL_POINT: pp_q    <= cfg_data_i[31:0];
        REG_INVERSE_FOCAL:   ifoc_q  <= cfg_data_i[47:0];
        REG_INV_DEPTH_SCALE: ids_q   <= cfg_data_i[23:0];
        REG_ROTATION_ROW0:   row0_q  <= cfg_data_i[59:0];
        REG_ROTATION_ROW1:   row1_q  <= cfg_data_i[59:0];
        REG_ROTATION_ROW2:   row2_q  <= cfg_data_i[59:0];
        REG_TRANSLATION:     trans_q <= cfg_data_i[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.cx              = pp_q[15:0];
    cfg_o.cy              = pp_q[31:16];
    cfg_o.inv_fx          = ifoc_q[23:0];
    cfg_o.inv_fy          = ifoc_q[47:24];
    cfg_o.inv_depth_scale = ids_q;
    cfg_o.rot[0]          = row0_q;
    cfg_o.rot[1]          = row1_q;
    cfg_o.rot[2]          = row2_q;
    cfg_o.trans           = trans_q;
  end

endmodule

// File: rtl/core/dpwp_camera.sv
// four-stage back-projection of a pixel into a camera-frame point
module dpwp_camera #(
  parameter int unsigned COLUMN_LIMIT = 2048,
  parameter int unsigned ROW_LIMIT    = 2048
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpwp_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dpwp_pkg::pix_t pix_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dpwp_pkg::pt_t  pt_o
);
  import dpwp_pkg::*;

  logic [3:0] vld_q, vld_d, adv;
  logic       keep;

  // stage 1
  logic [39:0]        zprod_q, zprod_d;
  logic signed [16:0] du_q, du_d, dv_q, dv_d;
  color_t             col1_q;
  // stage 2
  logic signed [41:0] nxp, nyp;
  logic [31:0]        z16_q, z16_d;
  logic signed [29:0] nx_q, nx_d, ny_q, ny_d;
  color_t             col2_q;
  // stage 3
  logic signed [62:0] xprod_q, xprod_d, yprod_q, yprod_d;
  logic [31:0]        z16b_q;
  color_t             col3_q;
  // stage 4
  pt_t                pt_q, pt_d;

  always_comb begin
    adv[3] = !vld_q[3] || out_ready_i;
    adv[2] = !vld_q[2] || adv[3];
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[3];
  assign pt_o        = pt_q;

  assign keep = (pix_i.depth != '0)
             && (PIX_CMP_W'(pix_i.column) < PIX_CMP_W'(COLUMN_LIMIT))
             && (PIX_CMP_W'(pix_i.row) < PIX_CMP_W'(ROW_LIMIT));

  always_comb begin
    vld_d[0] = adv[0] ? (in_valid_i && keep) : vld_q[0];
    vld_d[1] = adv[1] ? vld_q[0] : vld_q[1];
    vld_d[2] = adv[2] ? vld_q[1] : vld_q[2];
    vld_d[3] = adv[3] ? vld_q[2] : vld_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // depth scale product and centered pixel offsets in Q.4
  always_comb begin
    zprod_d = 40'(pix_i.depth) * 40'(cfg_i.inv_depth_scale);
    du_d    = $signed({2'b00, pix_i.column, 4'b0000}) - $signed({1'b0, cfg_i.cx});
    dv_d    = $signed({2'b00, pix_i.row, 4'b0000}) - $signed({1'b0, cfg_i.cy});
  end

  // normalized offsets in Q.16 and depth in Q.16
  always_comb begin
    nxp   = 42'(du_q) * 42'($signed({1'b0, cfg_i.inv_fx}));
    nyp   = 42'(dv_q) * 42'($signed({1'b0, cfg_i.inv_fy}));
    nx_d  = 30'((nxp + 42'sd2048) >>> 12);
    ny_d  = 30'((nyp + 42'sd2048) >>> 12);
    z16_d = 32'((zprod_q + 40'd128) >> 8);
  end

  always_comb begin
    xprod_d = 63'(nx_q) * 63'($signed({1'b0, z16_q}));
    yprod_d = 63'(ny_q) * 63'($signed({1'b0, z16_q}));
  end

  always_comb begin
    pt_d.x     = sat32(64'((xprod_q + 63'sd32768) >>> 16));
    pt_d.y     = sat32(64'((yprod_q + 63'sd32768) >>> 16));
    pt_d.z     = sat32(64'($signed({1'b0, z16b_q})));
    pt_d.color = col3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      zprod_q <= zprod_d;
      du_q    <= du_d;
      dv_q    <= dv_d;
      col1_q  <= pix_i.color;
    end
    if (adv[1]) begin
      z16_q  <= z16_d;
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      col2_q <= col1_q;
    end
    if (adv[2]) begin
      xprod_q <= xprod_d;
      yprod_q <= yprod_d;
      z16b_q  <= z16_q;
      col3_q  <= col2_q;
    end
    if (adv[3]) begin
      pt_q <= pt_d;
    end
  end

endmodule

// File: rtl/core/dpwp_pose.sv
// three-stage rigid transform, axis reorder and saturation
module dpwp_pose (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpwp_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dpwp_pkg::pt_t  pt_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dpwp_pkg::pt_t  pt_o
);
  import dpwp_pkg::*;

  logic [2:0] vld_q, vld_d, adv;

  logic signed [31:0] p [3];
  logic signed [51:0] prod_q [3][3];
  logic signed [51:0] prod_d [3][3];
  color_t             col1_q, col2_q;
  logic signed [53:0] acc [3];
  logic signed [35:0] r_q [3];
  logic signed [35:0] r_d [3];
  logic signed [37:0] w [3];
  pt_t                pt_q, pt_d;

  always_comb begin
    adv[2] = !vld_q[2] || out_ready_i;
    adv[1] = !vld_q[1] || adv[2];
    adv[0] = !vld_q[0] || adv[1];
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[2];
  assign pt_o        = pt_q;

  always_comb begin
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    vld_d[1] = adv[1] ? vld_q[0] : vld_q[1];
    vld_d[2] = adv[2] ? vld_q[1] : vld_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    p[0] = pt_i.x;
    p[1] = pt_i.y;
    p[2] = pt_i.z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = 52'($signed(cfg_i.rot[i][j])) * 52'(p[j]);
      end
    end
  end

  // row sums rounded from Q.34 back to Q.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 54'(prod_q[i][0]) + 54'(prod_q[i][1]) + 54'(prod_q[i][2]);
      r_d[i] = 36'((acc[i] + 54'sd131072) >>> 18);
    end
  end

  // world (x, z, -y)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = 38'(r_q[i]) + 38'($signed(cfg_i.trans[i]));
    end
    pt_d.x     = sat32(64'(w[0]));
    pt_d.y     = sat32(64'(w[2]));
    pt_d.z     = sat32(64'(-w[1]));
    pt_d.color = col2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      prod_q <= prod_d;
      col1_q <= pt_i.color;
    end
    if (adv[1]) begin
      r_q    <= r_d;
      col2_q <= col1_q;
    end
    if (adv[2]) begin
      pt_q <= pt_d;
    end
  end

endmodule
